FILE: rtl/fbpa_pkg.sv
// shared types and constants of the fixed block pool allocator
package fbpa_pkg;

    localparam int CMD_W    = 2;
    localparam int BIDX_W   = 8;
    localparam int CNT_W    = 9;
    localparam int PAY_W    = 16;
    localparam int BASE_W   = 32;
    localparam int OADDR_W  = 32;
    localparam int STRIDE_W = 17;
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;
    localparam int REGSEL_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_INIT  = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_BAD   = 2'd2
    } t_status;

    typedef enum logic [REGSEL_W-1:0] {
        REG_POOL_BLOCKS   = 2'd0,
        REG_PAYLOAD_BYTES = 2'd1,
        REG_BASE_ADDRESS  = 2'd2
    } t_reg_sel;

    localparam logic [CNT_W-1:0]  POOL_BLOCKS_RST   = 9'd256;
    localparam logic [PAY_W-1:0]  PAYLOAD_BYTES_RST = 16'd64;
    localparam logic [BASE_W-1:0] BASE_ADDRESS_RST  = 32'd0;

endpackage

FILE: rtl/fixed_block_pool_allocator_top.sv
// fixed block pool allocator: lifo free list of equal-size blocks with next links in a ram
//
// Each transaction carries allocate, free or initialize and returns one result with the
// block index, its data address (base + index * stride + align, stride = payload rounded
// up to the alignment plus one header word) and the free, used and peak-used counts.
// Allocate, free and the unused command code go from idle (accept; link ram read for
// allocate) to exec (take read data, write back, load the result register once free).
// Initialize does one link ram write per block in the init state. Double free is not
// detected. A result waits in an output register; the next transaction can be accepted
// while it waits, but is not finished until the register is free. The user must write
// configuration only while no transaction is outstanding; the block does not enforce it.
module fixed_block_pool_allocator_top #(
    parameter int MAX_BLOCKS  = 256,
    parameter int ADDR_BITS   = 32,
    parameter int ALIGN_BYTES = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [fbpa_pkg::CMD_W-1:0]    i_command,
    input  logic [fbpa_pkg::BIDX_W-1:0]   i_block_index,

    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [1:0]                    o_status,
    output logic [fbpa_pkg::BIDX_W-1:0]   o_granted_index,
    output logic [fbpa_pkg::OADDR_W-1:0]  o_data_address,
    output logic [fbpa_pkg::CNT_W-1:0]    o_free_count,
    output logic [fbpa_pkg::CNT_W-1:0]    o_used_count,
    output logic [fbpa_pkg::CNT_W-1:0]    o_peak_used,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fbpa_pkg::PADDR_W-1:0]  paddr,
    input  logic [fbpa_pkg::PDATA_W-1:0]  pwdata,
    output logic [fbpa_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    localparam int IDX_W   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int LINK_W  = IDX_W + 1;
    localparam int PROD_W  = IDX_W + fbpa_pkg::STRIDE_W;
    localparam int SUM_W   = ((PROD_W > fbpa_pkg::BASE_W) ? PROD_W : fbpa_pkg::BASE_W) + 2;
    localparam int WIDE_W  = IDX_W + fbpa_pkg::CNT_W;
    localparam logic [fbpa_pkg::OADDR_W-1:0] ADDR_MASK = (ADDR_BITS >= 32) ?
        32'hFFFF_FFFF : 32'((64'd1 << ADDR_BITS) - 64'd1);
    localparam logic [fbpa_pkg::STRIDE_W-1:0] ALIGN_M1 =
        fbpa_pkg::STRIDE_W'(ALIGN_BYTES - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_INIT,
        S_EXEC
    } t_state;

    // configuration registers
    logic [fbpa_pkg::CNT_W-1:0]  r_pool_blocks;
    logic [fbpa_pkg::PAY_W-1:0]  r_payload_bytes;
    logic [fbpa_pkg::BASE_W-1:0] r_base_address;

    // control and pool state
    t_state                      r_state,      n_state;
    fbpa_pkg::t_cmd              r_cmd,        n_cmd;
    logic                        r_free_bad,   n_free_bad;
    logic [IDX_W-1:0]            r_gidx,       n_gidx;
    logic [PROD_W-1:0]           r_prod,       n_prod;
    logic [IDX_W-1:0]            r_fill,       n_fill;
    logic [IDX_W-1:0]            r_head,       n_head;
    logic                        r_head_valid, n_head_valid;
    logic [fbpa_pkg::CNT_W-1:0]  r_pool_size,  n_pool_size;
    logic [fbpa_pkg::CNT_W-1:0]  r_free,       n_free;
    logic [fbpa_pkg::CNT_W-1:0]  r_used,       n_used;
    logic [fbpa_pkg::CNT_W-1:0]  r_peak,       n_peak;

    // result register
    logic                        r_out_valid,  n_out_valid;
    fbpa_pkg::t_status           r_status,     n_status;
    logic [fbpa_pkg::BIDX_W-1:0] r_out_idx,    n_out_idx;
    logic [fbpa_pkg::OADDR_W-1:0] r_out_addr,  n_out_addr;
    logic [fbpa_pkg::CNT_W-1:0]  r_out_free,   n_out_free;
    logic [fbpa_pkg::CNT_W-1:0]  r_out_used,   n_out_used;
    logic [fbpa_pkg::CNT_W-1:0]  r_out_peak,   n_out_peak;

    // link ram
    logic                        ram_we;
    logic [IDX_W-1:0]            ram_waddr;
    logic [LINK_W-1:0]           ram_wdata;
    logic                        ram_re;
    logic [LINK_W-1:0]           ram_rdata;

    logic                        in_accept;
    logic                        out_free;
    logic                        cfg_write;
    fbpa_pkg::t_reg_sel          cfg_sel;
    fbpa_pkg::t_cmd              in_cmd;
    logic [fbpa_pkg::STRIDE_W-1:0] stride;
    logic [IDX_W-1:0]            idx_sel;
    logic [SUM_W-1:0]            addr_sum;
    logic [fbpa_pkg::OADDR_W-1:0] blk_addr;
    logic [fbpa_pkg::CNT_W-1:0]  pool_n;
    logic                        fill_last;
    logic [fbpa_pkg::CNT_W-1:0]  used_inc;

    assign in_cmd    = fbpa_pkg::t_cmd'(i_command);
    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_sel   = fbpa_pkg::t_reg_sel'(paddr[3:2]);

    assign stride = ((fbpa_pkg::STRIDE_W'(r_payload_bytes) + ALIGN_M1) & ~ALIGN_M1)
                    + fbpa_pkg::STRIDE_W'(ALIGN_BYTES);
    assign idx_sel = (in_cmd == fbpa_pkg::CMD_ALLOC) ? r_head : IDX_W'(i_block_index);
    assign addr_sum = SUM_W'(r_base_address) + SUM_W'(r_prod) + SUM_W'(ALIGN_BYTES);
    assign blk_addr = addr_sum[fbpa_pkg::OADDR_W-1:0] & ADDR_MASK;
    assign pool_n = (32'(r_pool_blocks) < 32'(MAX_BLOCKS)) ?
                    r_pool_blocks : fbpa_pkg::CNT_W'(MAX_BLOCKS);
    assign fill_last = (WIDE_W'(r_fill) + WIDE_W'(1)) == WIDE_W'(r_pool_size);
    assign used_inc = (r_used < r_pool_size) ? r_used + 1'b1 : r_used;

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_free_bad   = r_free_bad;
        n_gidx       = r_gidx;
        n_prod       = r_prod;
        n_fill       = r_fill;
        n_head       = r_head;
        n_head_valid = r_head_valid;
        n_pool_size  = r_pool_size;
        n_free       = r_free;
        n_used       = r_used;
        n_peak       = r_peak;
        n_out_valid  = r_out_valid && i_out_stall;
        n_status     = r_status;
        n_out_idx    = r_out_idx;
        n_out_addr   = r_out_addr;
        n_out_free   = r_out_free;
        n_out_used   = r_out_used;
        n_out_peak   = r_out_peak;
        ram_we       = 1'b0;
        ram_waddr    = r_gidx;
        ram_wdata    = r_head_valid ? {1'b0, r_head} : {1'b1, IDX_W'(0)};
        ram_re       = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_cmd      = in_cmd;
                    n_gidx     = idx_sel;
                    n_prod     = PROD_W'(idx_sel) * PROD_W'(stride);
                    n_free_bad = {1'b0, i_block_index} >= r_pool_size;
                    n_fill     = '0;
                    n_state    = S_EXEC;
                    ram_re     = (in_cmd == fbpa_pkg::CMD_ALLOC);
                    if (in_cmd == fbpa_pkg::CMD_INIT) begin
                        n_pool_size  = pool_n;
                        n_head_valid = 1'b0;
                        n_head       = '0;
                        n_state      = (pool_n == '0) ? S_EXEC : S_INIT;
                    end
                end
            end
            S_INIT: begin
                ram_we    = 1'b1;
                ram_waddr = r_fill;
                ram_wdata = (r_fill == '0) ? {1'b1, IDX_W'(0)} : {1'b0, r_fill - 1'b1};
                if (fill_last) begin
                    n_state = S_EXEC;
                end else begin
                    n_fill = r_fill + 1'b1;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    n_status    = fbpa_pkg::STAT_OK;
                    n_out_idx   = '0;
                    n_out_addr  = '0;
                    case (r_cmd)
                        fbpa_pkg::CMD_ALLOC: begin
                            if (!r_head_valid) begin
                                n_status = fbpa_pkg::STAT_EMPTY;
                            end else begin
                                n_head_valid = !ram_rdata[IDX_W];
                                n_head       = ram_rdata[IDX_W] ? '0 : ram_rdata[IDX_W-1:0];
                                n_free       = (r_free != '0) ? r_free - 1'b1 : r_free;
                                n_used       = used_inc;
                                n_peak       = (used_inc > r_peak) ? used_inc : r_peak;
                                n_out_idx    = fbpa_pkg::BIDX_W'(r_gidx);
                                n_out_addr   = blk_addr;
                            end
                        end
                        fbpa_pkg::CMD_FREE: begin
                            if (r_free_bad) begin
                                n_status = fbpa_pkg::STAT_BAD;
                            end else begin
                                ram_we       = 1'b1;
                                n_head       = r_gidx;
                                n_head_valid = 1'b1;
                                n_free       = (r_free < r_pool_size) ? r_free + 1'b1 : r_free;
                                n_used       = (r_used != '0) ? r_used - 1'b1 : r_used;
                                n_out_idx    = fbpa_pkg::BIDX_W'(r_gidx);
                                n_out_addr   = blk_addr;
                            end
                        end
                        fbpa_pkg::CMD_INIT: begin
                            n_head       = r_fill;
                            n_head_valid = (r_pool_size != '0);
                            n_free       = r_pool_size;
                            n_used       = '0;
                            n_peak       = '0;
                        end
                        default: begin
                        end
                    endcase
                    n_out_free = n_free;
                    n_out_used = n_used;
                    n_out_peak = n_peak;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_head_valid <= 1'b0;
            r_head       <= '0;
            r_pool_size  <= '0;
            r_free       <= '0;
            r_used       <= '0;
            r_peak       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_head_valid <= n_head_valid;
            r_head       <= n_head;
            r_pool_size  <= n_pool_size;
            r_free       <= n_free;
            r_used       <= n_used;
            r_peak       <= n_peak;
            r_out_valid  <= n_out_valid;
        end
        r_cmd      <= n_cmd;
        r_free_bad <= n_free_bad;
        r_gidx     <= n_gidx;
        r_prod     <= n_prod;
        r_fill     <= n_fill;
        r_status   <= n_status;
        r_out_idx  <= n_out_idx;
        r_out_addr <= n_out_addr;
        r_out_free <= n_out_free;
        r_out_used <= n_out_used;
        r_out_peak <= n_out_peak;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_blocks   <= fbpa_pkg::POOL_BLOCKS_RST;
            r_payload_bytes <= fbpa_pkg::PAYLOAD_BYTES_RST;
            r_base_address  <= fbpa_pkg::BASE_ADDRESS_RST;
        end else if (cfg_write) begin
            case (cfg_sel)
                fbpa_pkg::REG_POOL_BLOCKS:   r_pool_blocks   <= pwdata[fbpa_pkg::CNT_W-1:0];
                fbpa_pkg::REG_PAYLOAD_BYTES: r_payload_bytes <= pwdata[fbpa_pkg::PAY_W-1:0];
                fbpa_pkg::REG_BASE_ADDRESS:  r_base_address  <= pwdata[fbpa_pkg::BASE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_sel)
            fbpa_pkg::REG_POOL_BLOCKS:   prdata = fbpa_pkg::PDATA_W'(r_pool_blocks);
            fbpa_pkg::REG_PAYLOAD_BYTES: prdata = fbpa_pkg::PDATA_W'(r_payload_bytes);
            fbpa_pkg::REG_BASE_ADDRESS:  prdata = r_base_address;
            default:                     prdata = '0;
        endcase
    end

    fbpa_ram #(
        .WIDTH (LINK_W),
        .DEPTH (MAX_BLOCKS)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_head),
        .o_rdata (ram_rdata)
    );

    assign pready          = 1'b1;
    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_granted_index = r_out_idx;
    assign o_data_address  = r_out_addr;
    assign o_free_count    = r_out_free;
    assign o_used_count    = r_out_used;
    assign o_peak_used     = r_out_peak;

    a_peak_covers_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_peak >= r_used)
        else $error("peak used count below used count");

    a_counts_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_used <= r_pool_size) && (r_free <= r_pool_size))
        else $error("free or used count above pool size");

    a_error_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_status != fbpa_pkg::STAT_OK))
        |-> (r_out_idx == '0) && (r_out_addr == '0))
        else $error("rejected transaction carries an index or address");

    a_accept_interlock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state != S_IDLE))
        else $error("accepted transaction did not leave idle");

endmodule

FILE: rtl/fbpa_ram.sv
// generic single write port ram with registered read
module fbpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: tb/sv/fbpa_grant_checker.sv
// transaction checker for the block pool allocator: tracks config writes, predicts and compares results
`timescale 1ns / 1ps

module fbpa_grant_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic [fbpa_pkg::CMD_W-1:0]    i_command,
    input  logic [fbpa_pkg::BIDX_W-1:0]   i_block_index,

    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic [1:0]                    i_status,
    input  logic [fbpa_pkg::BIDX_W-1:0]   i_granted_index,
    input  logic [fbpa_pkg::OADDR_W-1:0]  i_data_address,
    input  logic [fbpa_pkg::CNT_W-1:0]    i_free_count,
    input  logic [fbpa_pkg::CNT_W-1:0]    i_used_count,
    input  logic [fbpa_pkg::CNT_W-1:0]    i_peak_used,

    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic                          i_pready,
    input  logic [fbpa_pkg::PADDR_W-1:0]  i_paddr,
    input  logic [fbpa_pkg::PDATA_W-1:0]  i_pwdata,

    output int                            o_fail_count,
    output int                            o_pending
);

    localparam int POOL_MAX = 256;
    localparam int ALIGN    = 8;
    localparam logic [fbpa_pkg::CNT_W-1:0] LINK_TAIL = 9'h100;

    typedef struct packed {
        logic [1:0]                   status;
        logic [fbpa_pkg::BIDX_W-1:0]  index;
        logic [fbpa_pkg::OADDR_W-1:0] addr;
        logic [fbpa_pkg::CNT_W-1:0]   free_n;
        logic [fbpa_pkg::CNT_W-1:0]   used_n;
        logic [fbpa_pkg::CNT_W-1:0]   peak_n;
    } t_grant;

    // bit 8 of a link marks the tail of the free list
    logic [fbpa_pkg::CNT_W-1:0]  link_mem [POOL_MAX];
    logic [fbpa_pkg::BIDX_W-1:0] head_idx;
    logic                        head_ok;
    logic [fbpa_pkg::CNT_W-1:0]  free_total;
    logic [fbpa_pkg::CNT_W-1:0]  used_total;
    logic [fbpa_pkg::CNT_W-1:0]  peak_total;
    logic [fbpa_pkg::CNT_W-1:0]  pool_n;

    logic [fbpa_pkg::CNT_W-1:0]  cfg_blocks;
    logic [fbpa_pkg::PAY_W-1:0]  cfg_payload;
    logic [fbpa_pkg::BASE_W-1:0] cfg_base;

    t_grant grant_q [$];
    int     fail_total    = 0;
    int     pending_total = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = pending_total;

    function automatic logic [fbpa_pkg::OADDR_W-1:0] data_addr(
        input logic [fbpa_pkg::BIDX_W-1:0] idx);
        logic [fbpa_pkg::PAY_W:0] rounded;
        logic [63:0]              sum;
        rounded = ({1'b0, cfg_payload} + 17'(ALIGN - 1)) & ~17'(ALIGN - 1);
        sum = 64'(cfg_base) + 64'(idx) * (64'(rounded) + 64'(ALIGN)) + 64'(ALIGN);
        return sum[fbpa_pkg::OADDR_W-1:0];
    endfunction

    task automatic advance_pool(input logic [fbpa_pkg::CMD_W-1:0] cmd,
                                input logic [fbpa_pkg::BIDX_W-1:0] bidx,
                                output t_grant g);
        logic [fbpa_pkg::CNT_W-1:0] lk;
        logic [fbpa_pkg::CNT_W-1:0] n;
        g = '0;
        case (cmd)
            fbpa_pkg::CMD_ALLOC: begin
                if (!head_ok) begin
                    g.status = fbpa_pkg::STAT_EMPTY;
                end else begin
                    lk = link_mem[head_idx];
                    g.index = head_idx;
                    g.addr = data_addr(head_idx);
                    head_ok = !lk[fbpa_pkg::CNT_W-1];
                    head_idx = lk[fbpa_pkg::CNT_W-1] ? '0 : lk[fbpa_pkg::BIDX_W-1:0];
                    if (free_total > 0) free_total = free_total - 1'b1;
                    if (used_total < pool_n) used_total = used_total + 1'b1;
                    if (used_total > peak_total) peak_total = used_total;
                end
            end
            fbpa_pkg::CMD_FREE: begin
                if ({1'b0, bidx} >= pool_n) begin
                    g.status = fbpa_pkg::STAT_BAD;
                end else begin
                    link_mem[bidx] = head_ok ? {1'b0, head_idx} : LINK_TAIL;
                    head_idx = bidx;
                    head_ok = 1'b1;
                    if (free_total < pool_n) free_total = free_total + 1'b1;
                    if (used_total > 0) used_total = used_total - 1'b1;
                    g.index = bidx;
                    g.addr = data_addr(bidx);
                end
            end
            fbpa_pkg::CMD_INIT: begin
                n = (cfg_blocks > POOL_MAX) ? fbpa_pkg::CNT_W'(POOL_MAX) : cfg_blocks;
                pool_n = n;
                for (int i = 0; i < int'(n); i++) begin
                    link_mem[i] = (i == 0) ? LINK_TAIL : fbpa_pkg::CNT_W'(i - 1);
                end
                head_ok = (n != 0);
                head_idx = (n != 0) ? fbpa_pkg::BIDX_W'(n - 1'b1) : '0;
                free_total = n;
                used_total = '0;
                peak_total = '0;
            end
            default: begin
            end
        endcase
        g.free_n = free_total;
        g.used_n = used_total;
        g.peak_n = peak_total;
    endtask

    task automatic check_field(input string what, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (got_v !== want_v) begin
            fail_total++;
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want_v, got_v);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_grant want;
        if (!i_rst_n) begin
            head_idx = '0;
            head_ok = 1'b0;
            free_total = '0;
            used_total = '0;
            peak_total = '0;
            pool_n = '0;
            cfg_blocks = fbpa_pkg::POOL_BLOCKS_RST;
            cfg_payload = fbpa_pkg::PAYLOAD_BYTES_RST;
            cfg_base = fbpa_pkg::BASE_ADDRESS_RST;
            grant_q.delete();
            pending_total = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[fbpa_pkg::PADDR_W-1:2])
                    fbpa_pkg::REG_POOL_BLOCKS:   cfg_blocks = i_pwdata[fbpa_pkg::CNT_W-1:0];
                    fbpa_pkg::REG_PAYLOAD_BYTES: cfg_payload = i_pwdata[fbpa_pkg::PAY_W-1:0];
                    fbpa_pkg::REG_BASE_ADDRESS:  cfg_base = i_pwdata[fbpa_pkg::BASE_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (grant_q.size() == 0) begin
                    fail_total++;
                    $display("%0t ns: result with none expected, got status %0h index %0h",
                             $time, i_status, i_granted_index);
                end else begin
                    want = grant_q.pop_front();
                    check_field("status", 32'(want.status), 32'(i_status));
                    check_field("granted_index", 32'(want.index), 32'(i_granted_index));
                    check_field("data_address", want.addr, i_data_address);
                    check_field("free_count", 32'(want.free_n), 32'(i_free_count));
                    check_field("used_count", 32'(want.used_n), 32'(i_used_count));
                    check_field("peak_used", 32'(want.peak_n), 32'(i_peak_used));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                advance_pool(i_command, i_block_index, want);
                grant_q.push_back(want);
            end
            pending_total = grant_q.size();
        end
    end

endmodule

FILE: tb/sv/tb_fixed_block_pool_allocator_top.sv
// testbench top for the block pool allocator: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_fixed_block_pool_allocator_top;

    localparam logic [fbpa_pkg::CMD_W-1:0] CMD_NOP = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 2000000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_OPS   = 220;
    localparam int PHASES      = 8;

    logic                           i_clk   = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_in_valid;
    logic                           o_in_stall;
    logic [fbpa_pkg::CMD_W-1:0]     i_command;
    logic [fbpa_pkg::BIDX_W-1:0]    i_block_index;
    logic                           o_out_valid;
    logic                           i_out_stall;
    logic [1:0]                     o_status;
    logic [fbpa_pkg::BIDX_W-1:0]    o_granted_index;
    logic [fbpa_pkg::OADDR_W-1:0]   o_data_address;
    logic [fbpa_pkg::CNT_W-1:0]     o_free_count;
    logic [fbpa_pkg::CNT_W-1:0]     o_used_count;
    logic [fbpa_pkg::CNT_W-1:0]     o_peak_used;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [fbpa_pkg::PADDR_W-1:0]   paddr;
    logic [fbpa_pkg::PDATA_W-1:0]   pwdata;
    logic [fbpa_pkg::PDATA_W-1:0]   prdata;
    logic                           pready;

    int          fail_count;
    int          pending_n;
    int          holds_asked  = 0;
    int          holds_served = 0;
    int unsigned cycle_n      = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    fixed_block_pool_allocator_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_command       (i_command),
        .i_block_index   (i_block_index),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_granted_index (o_granted_index),
        .o_data_address  (o_data_address),
        .o_free_count    (o_free_count),
        .o_used_count    (o_used_count),
        .o_peak_used     (o_peak_used),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    fbpa_grant_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_command       (i_command),
        .i_block_index   (i_block_index),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_status        (o_status),
        .i_granted_index (o_granted_index),
        .i_data_address  (o_data_address),
        .i_free_count    (o_free_count),
        .i_used_count    (o_used_count),
        .i_peak_used     (o_peak_used),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_pready        (pready),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .o_fail_count    (fail_count),
        .o_pending       (pending_n)
    );

    always @(posedge i_clk) begin
        cycle_n++;
        if (cycle_n >= CYCLE_LIMIT) begin
            $display("fixed_block_pool_allocator_top regression: fail");
            $finish;
        end
    end

    function automatic int pick_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50) return 0;
        if (pick < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // called at a falling edge; returns at the falling edge after the transaction
    task automatic send_op(input logic [fbpa_pkg::CMD_W-1:0] cmd,
                           input logic [fbpa_pkg::BIDX_W-1:0] idx);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_command = cmd;
        i_block_index = idx;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    task automatic settle();
        i_in_valid = 1'b0;
        while (pending_n != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input fbpa_pkg::t_reg_sel sel,
                             input logic [fbpa_pkg::PDATA_W-1:0] value);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {sel, 2'b00};
        pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic set_pool(input logic [fbpa_pkg::CNT_W-1:0] blocks,
                            input logic [fbpa_pkg::PAY_W-1:0] bytes,
                            input logic [fbpa_pkg::BASE_W-1:0] base);
        settle();
        write_reg(fbpa_pkg::REG_POOL_BLOCKS, fbpa_pkg::PDATA_W'(blocks));
        write_reg(fbpa_pkg::REG_PAYLOAD_BYTES, fbpa_pkg::PDATA_W'(bytes));
        write_reg(fbpa_pkg::REG_BASE_ADDRESS, fbpa_pkg::PDATA_W'(base));
    endtask

    task automatic random_ops(input int count, input int n);
        int pick;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                send_op(fbpa_pkg::CMD_ALLOC, fbpa_pkg::BIDX_W'($urandom));
            end else if (pick < 86) begin
                send_op(fbpa_pkg::CMD_FREE,
                        (n > 0) ? fbpa_pkg::BIDX_W'($urandom_range(0, n - 1))
                                : fbpa_pkg::BIDX_W'($urandom));
            end else if (pick < 94) begin
                send_op(fbpa_pkg::CMD_FREE, fbpa_pkg::BIDX_W'($urandom));
            end else if (pick < 98) begin
                send_op(CMD_NOP, fbpa_pkg::BIDX_W'($urandom));
            end else begin
                send_op(fbpa_pkg::CMD_INIT, fbpa_pkg::BIDX_W'($urandom));
            end
        end
    endtask

    initial begin : drain
        int span;
        int pick;
        i_out_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (holds_served < holds_asked) begin
                i_out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                holds_served++;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 55) begin
                    i_out_stall = 1'b0;
                    span = $urandom_range(1, 24);
                end else if (pick < 93) begin
                    i_out_stall = 1'b1;
                    span = $urandom_range(1, 3);
                end else begin
                    i_out_stall = 1'b1;
                    span = $urandom_range(12, 40);
                end
                repeat (span) @(negedge i_clk);
            end
        end
    end

    initial begin : stimulus
        logic [fbpa_pkg::CNT_W-1:0]  blocks;
        logic [fbpa_pkg::PAY_W-1:0]  bytes;
        logic [fbpa_pkg::BASE_W-1:0] base;
        int                          n;
        i_in_valid = 1'b0;
        i_command = fbpa_pkg::CMD_ALLOC;
        i_block_index = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // nothing initialized yet: frees rejected, allocate finds the list empty
        send_op(fbpa_pkg::CMD_FREE, 8'd0);
        send_op(fbpa_pkg::CMD_ALLOC, 8'hff);
        send_op(CMD_NOP, 8'hff);
        send_op(fbpa_pkg::CMD_FREE, 8'hff);

        // tiny pool, smallest payload, addresses wrapping past the top
        set_pool(9'd4, 16'd1, 32'hffff_fff0);
        send_op(fbpa_pkg::CMD_INIT, 8'd0);
        repeat (5) send_op(fbpa_pkg::CMD_ALLOC, 8'd0);
        send_op(fbpa_pkg::CMD_FREE, 8'd0);
        send_op(fbpa_pkg::CMD_FREE, 8'd0);
        send_op(fbpa_pkg::CMD_FREE, 8'd4);
        send_op(fbpa_pkg::CMD_FREE, 8'hff);
        repeat (3) send_op(fbpa_pkg::CMD_ALLOC, 8'd0);
        send_op(fbpa_pkg::CMD_INIT, 8'd0);
        send_op(CMD_NOP, 8'd0);

        // full pool, largest payload, largest base
        set_pool(9'd256, 16'hffff, 32'hffff_ffff);
        send_op(fbpa_pkg::CMD_INIT, 8'd0);
        send_op(fbpa_pkg::CMD_ALLOC, 8'd0);
        send_op(fbpa_pkg::CMD_FREE, 8'hff);
        send_op(fbpa_pkg::CMD_FREE, 8'd0);
        send_op(fbpa_pkg::CMD_ALLOC, 8'd0);

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin
                    blocks = 9'd1;
                    bytes = 16'd1;
                    base = 32'd0;
                end
                1: begin
                    blocks = 9'd8;
                    bytes = 16'hffff;
                    base = 32'hffff_ffff;
                end
                2: begin
                    blocks = 9'd256;
                    bytes = fbpa_pkg::PAY_W'($urandom_range(1, 65535));
                    base = $urandom;
                end
                3: begin
                    blocks = 9'd0;
                    bytes = fbpa_pkg::PAY_W'($urandom_range(1, 65535));
                    base = $urandom;
                end
                4: begin
                    blocks = 9'h1ff;
                    bytes = 16'd8;
                    base = $urandom;
                end
                default: begin
                    blocks = fbpa_pkg::CNT_W'($urandom_range(2, 32));
                    bytes = fbpa_pkg::PAY_W'($urandom_range(1, 65535));
                    base = $urandom;
                end
            endcase
            n = (blocks > 256) ? 256 : int'(blocks);
            set_pool(blocks, bytes, base);
            // long receiver hold while items keep coming
            if (ph == 1) holds_asked++;
            send_op(fbpa_pkg::CMD_INIT, fbpa_pkg::BIDX_W'($urandom));
            random_ops(PHASE_OPS, n);
        end

        settle();
        repeat (8) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("fixed_block_pool_allocator_top regression: pass");
        end else begin
            $display("fixed_block_pool_allocator_top regression: fail");
        end
        $finish;
    end

endmodule
